FILE: rtl/core/cdq_pkg.sv
// Shared types and constants for the circular deque with search.
// Operation and status codes, field widths and the result record.
// No dependencies.
package cdq_pkg;

    // Field widths of the request and result channels.
    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 8;
    localparam int TOTAL_W  = 9;

    // Default number of entries in the store.
    localparam int CAPACITY_DEFAULT = 256;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_FIND       = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_DELETE     = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // One result record.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] popped_value;
        logic [POS_W-1:0]         position;
        logic [TOTAL_W-1:0]       entry_total;
    } res_t;

endpackage

FILE: rtl/core/cdq_if.sv
// Valid/ready channel interfaces for requests and results of the deque.
// Depends on cdq_pkg.
interface cdq_req_if;
    logic                              valid;
    logic                              ready;
    logic [cdq_pkg::FUNC_W-1:0]        func;
    logic signed [cdq_pkg::DATA_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface cdq_res_if;
    logic                              valid;
    logic                              ready;
    logic [cdq_pkg::STATUS_W-1:0]      status;
    logic signed [cdq_pkg::DATA_W-1:0] popped_value;
    logic [cdq_pkg::POS_W-1:0]         position;
    logic [cdq_pkg::TOTAL_W-1:0]       entry_total;

    modport source (output valid, output status, output popped_value,
                    output position, output entry_total, input ready);
    modport sink   (input valid, input status, input popped_value,
                    input position, input entry_total, output ready);
endinterface

FILE: rtl/core/cdq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds while no read is enabled.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/cdq_ctrl.sv
// Sequencer of the deque: front pointer, entry count and the scan and shift
// walks over the value store. Depends on cdq_pkg and cdq_if.
module cdq_ctrl #(
    parameter int CAPACITY = cdq_pkg::CAPACITY_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cdq_req_if.sink                           req,
    // Store access.
    output logic                              mem_wr_en,
    output logic [$clog2(CAPACITY)-1:0]       mem_wr_addr,
    output logic [cdq_pkg::DATA_W-1:0]        mem_wr_data,
    output logic                              mem_rd_en,
    output logic [$clog2(CAPACITY)-1:0]       mem_rd_addr,
    input  logic [cdq_pkg::DATA_W-1:0]        mem_rd_data,
    // Finished result toward the output register.
    output logic                              done_valid,
    input  logic                              done_free,
    output cdq_pkg::res_t                     done_res
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = CNT_W + 1;
    localparam int PEXT_W = (IDX_W > cdq_pkg::POS_W) ? IDX_W : cdq_pkg::POS_W;
    localparam int TEXT_W = (CNT_W > cdq_pkg::TOTAL_W) ? CNT_W : cdq_pkg::TOTAL_W;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);
    localparam logic [IDX_W:0]   CAP_SUM   = (IDX_W + 1)'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t                         state_reg, state_next;
    logic [IDX_W-1:0]               front_reg, front_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [cdq_pkg::FUNC_W-1:0]     func_reg, func_next;
    logic [cdq_pkg::DATA_W-1:0]     value_reg, value_next;
    logic [IDX_W-1:0]               off_reg, off_next;
    logic [IDX_W-1:0]               pos_reg, pos_next;
    logic [cdq_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic                           pop_reg, pop_next;

    logic                           full;
    logic                           empty;
    logic [IDX_W-1:0]               front_dec;
    logic [IDX_W-1:0]               front_inc;
    logic [EXT_W-1:0]               cnt_ext;
    logic [EXT_W-1:0]               off_p1;
    logic [EXT_W-1:0]               off_p2;
    logic [PEXT_W-1:0]              pos_ext;
    logic [TEXT_W-1:0]              total_ext;

    // Physical slot of an entry given its offset from the front.
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                                 input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, front} + {1'b0, off};
        if (sum >= CAP_SUM)
        begin
            sum = sum - CAP_SUM;
        end
        return sum[IDX_W-1:0];
    endfunction

    // Pointer and count helpers.
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - 1'b1;
    assign front_inc = (front_reg == LAST_SLOT) ? '0 : front_reg + 1'b1;
    assign cnt_ext   = EXT_W'(count_reg);
    assign off_p1    = EXT_W'(off_reg) + EXT_W'(1);
    assign off_p2    = EXT_W'(off_reg) + EXT_W'(2);

    // Result record, formed from the held request state.
    assign pos_ext   = PEXT_W'(pos_reg);
    assign total_ext = TEXT_W'(count_reg);
    assign done_valid = (state_reg == S_DONE);
    always_comb
    begin
        done_res.status       = status_reg;
        done_res.popped_value = pop_reg ? mem_rd_data : '0;
        done_res.position     = pos_ext[cdq_pkg::POS_W-1:0];
        done_res.entry_total  = total_ext[cdq_pkg::TOTAL_W-1:0];
    end

    assign req.ready = (state_reg == S_IDLE);

    // Next-state logic and store access.
    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        func_next   = func_reg;
        value_next  = value_reg;
        off_next    = off_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        pop_next    = pop_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next   = req.func;
                    value_next  = req.value;
                    pos_next    = '0;
                    pop_next    = 1'b0;
                    status_next = cdq_pkg::STATUS_OK;
                    off_next    = '0;
                    state_next  = S_DONE;
                    case (req.func)
                        cdq_pkg::FUNC_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = cdq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = front_dec;
                                mem_wr_data = req.value;
                                front_next  = front_dec;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        cdq_pkg::FUNC_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = cdq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = slot_of(front_reg, count_reg[IDX_W-1:0]);
                                mem_wr_data = req.value;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        cdq_pkg::FUNC_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = cdq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = front_reg;
                                front_next  = front_inc;
                                count_next  = count_reg - 1'b1;
                                pop_next    = 1'b1;
                            end
                        end
                        cdq_pkg::FUNC_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = cdq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = slot_of(front_reg,
                                                      IDX_W'(count_reg - 1'b1));
                                count_next  = count_reg - 1'b1;
                                pop_next    = 1'b1;
                            end
                        end
                        cdq_pkg::FUNC_FIND, cdq_pkg::FUNC_DELETE:
                        begin
                            if (empty)
                            begin
                                status_next = cdq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = front_reg;
                                state_next  = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // One entry compared per cycle; the next one is fetched ahead.
            S_SCAN:
            begin
                if (off_p1 < cnt_ext)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = slot_of(front_reg, off_p1[IDX_W-1:0]);
                end
                if (mem_rd_data == value_reg)
                begin
                    pos_next   = off_reg;
                    state_next = (func_reg == cdq_pkg::FUNC_FIND) ? S_DONE : S_SHIFT;
                end
                else if (off_p1 == cnt_ext)
                begin
                    status_next = cdq_pkg::STATUS_EMPTY;
                    state_next  = S_DONE;
                end
                else
                begin
                    off_next = off_p1[IDX_W-1:0];
                end
            end

            // Move each later entry one place toward the front.
            S_SHIFT:
            begin
                if (off_p1 < cnt_ext)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = slot_of(front_reg, off_reg);
                    mem_wr_data = mem_rd_data;
                    if (off_p2 < cnt_ext)
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = slot_of(front_reg, off_p2[IDX_W-1:0]);
                    end
                    off_next = off_p1[IDX_W-1:0];
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (done_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and request registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            count_reg  <= '0;
            func_reg   <= '0;
            value_reg  <= '0;
            off_reg    <= '0;
            pos_reg    <= '0;
            status_reg <= cdq_pkg::STATUS_OK;
            pop_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            count_reg  <= count_next;
            func_reg   <= func_next;
            value_reg  <= value_next;
            off_reg    <= off_next;
            pos_reg    <= pos_next;
            status_reg <= status_next;
            pop_reg    <= pop_next;
        end
    end

endmodule

FILE: rtl/core/circular_deque_with_search.sv
// Bounded deque of 32-bit values with search. Pushes, pops and unused codes
// go from the request transfer straight to the result handoff. Find reads the
// store once per entry, from the front up to a match at position p; delete
// then shifts the later entries one place each through the store port.
// A new request is taken once the previous result is in the output register.
// Reset clears pointer, count and handshakes; the store needs no clearing pass.
module circular_deque_with_search #(
    parameter int CAPACITY = cdq_pkg::CAPACITY_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    cdq_req_if.sink    req,
    cdq_res_if.source  res
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic                        mem_wr_en;
    logic [IDX_W-1:0]            mem_wr_addr;
    logic [cdq_pkg::DATA_W-1:0]  mem_wr_data;
    logic                        mem_rd_en;
    logic [IDX_W-1:0]            mem_rd_addr;
    logic [cdq_pkg::DATA_W-1:0]  mem_rd_data;
    logic                        done_valid;
    logic                        done_free;
    cdq_pkg::res_t               done_res;
    logic                        out_valid_reg, out_valid_next;
    cdq_pkg::res_t               out_res_reg;

    // Value store.
    cdq_ram #(
        .WIDTH (cdq_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Request sequencer.
    cdq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .done_valid  (done_valid),
        .done_free   (done_free),
        .done_res    (done_res)
    );

    // Output register: free when empty or its result leaves this cycle.
    assign done_free      = !out_valid_reg || res.ready;
    assign out_valid_next = done_valid || (out_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_valid && done_free)
        begin
            out_res_reg <= done_res;
        end
    end

    // Result channel.
    assign res.valid        = out_valid_reg;
    assign res.status       = out_res_reg.status;
    assign res.popped_value = out_res_reg.popped_value;
    assign res.position     = out_res_reg.position;
    assign res.entry_total  = out_res_reg.entry_total;

endmodule

FILE: tb/tb_circular_deque_with_search.sv
// Self-checking testbench for circular_deque_with_search.
// Runs a table of directed requests, then random traffic, against a predictor.
// Depends on cdq_pkg, cdq_req_if and cdq_res_if from the RTL.
module tb_circular_deque_with_search;

    localparam int DEPTH  = cdq_pkg::CAPACITY_DEFAULT;
    localparam int SLOT_W = $clog2(DEPTH);

    // Codes outside the defined set; the block must treat them as no-ops.
    localparam logic [cdq_pkg::FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
    localparam logic [cdq_pkg::FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

    // One row of the directed table.
    typedef struct {
        logic [cdq_pkg::FUNC_W-1:0] op;
        logic [cdq_pkg::DATA_W-1:0] arg;
        bit                         typed;
        cdq_pkg::res_t              want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    cdq_req_if req_ch ();
    cdq_res_if res_ch ();

    circular_deque_with_search DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // Predictor state: a copy of the deque contents.
    logic [cdq_pkg::DATA_W-1:0] deque_mem [DEPTH];
    int                         deque_front = 0;
    int                         deque_count = 0;

    // Results still owed by the block, oldest first.
    cdq_pkg::res_t owed_results [$];
    dir_row_t      dir_rows [$];

    int error_count    = 0;
    int result_count   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at result %0d: %s", result_count, what);
    endtask

    // Store slot of the predicted entry at a given offset from the front.
    function automatic logic [SLOT_W-1:0] slot_at(input int off);
        return SLOT_W'((deque_front + off) % DEPTH);
    endfunction

    // Applies one request to the predicted deque and returns its result.
    function automatic cdq_pkg::res_t deque_apply(input logic [cdq_pkg::FUNC_W-1:0] op,
                                                  input logic [cdq_pkg::DATA_W-1:0] arg);
        cdq_pkg::res_t r;
        int            hit;
        r   = '0;
        hit = -1;
        case (op)
            cdq_pkg::FUNC_PUSH_FRONT:
                if (deque_count >= DEPTH)
                begin
                    r.status = cdq_pkg::STATUS_FULL;
                end
                else
                begin
                    deque_front             = (deque_front + DEPTH - 1) % DEPTH;
                    deque_mem[slot_at(0)]   = arg;
                    deque_count++;
                end
            cdq_pkg::FUNC_PUSH_BACK:
                if (deque_count >= DEPTH)
                begin
                    r.status = cdq_pkg::STATUS_FULL;
                end
                else
                begin
                    deque_mem[slot_at(deque_count)] = arg;
                    deque_count++;
                end
            cdq_pkg::FUNC_POP_FRONT:
                if (deque_count == 0)
                begin
                    r.status = cdq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    r.popped_value = deque_mem[slot_at(0)];
                    deque_front    = (deque_front + 1) % DEPTH;
                    deque_count--;
                end
            cdq_pkg::FUNC_POP_BACK:
                if (deque_count == 0)
                begin
                    r.status = cdq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    r.popped_value = deque_mem[slot_at(deque_count - 1)];
                    deque_count--;
                end
            cdq_pkg::FUNC_FIND, cdq_pkg::FUNC_DELETE:
            begin
                // First match from the front; a delete then closes the gap.
                for (int i = 0; i < deque_count && hit < 0; i++)
                begin
                    if (deque_mem[slot_at(i)] == arg)
                    begin
                        hit = i;
                    end
                end
                if (hit < 0)
                begin
                    r.status = cdq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    r.position = hit[cdq_pkg::POS_W-1:0];
                    if (op == cdq_pkg::FUNC_DELETE)
                    begin
                        for (int i = hit; i + 1 < deque_count; i++)
                        begin
                            deque_mem[slot_at(i)] = deque_mem[slot_at(i + 1)];
                        end
                        deque_count--;
                    end
                end
            end
            default:
                ;
        endcase
        r.entry_total = deque_count[cdq_pkg::TOTAL_W-1:0];
        return r;
    endfunction

    // Picks a value: often one already held, sometimes an extreme or a tiny one.
    function automatic logic [cdq_pkg::DATA_W-1:0] pick_value(input int held_pct);
        int                         roll;
        logic [cdq_pkg::DATA_W-1:0] v;
        roll = $urandom_range(99);
        if (deque_count > 0 && roll < held_pct)
        begin
            v = deque_mem[slot_at(int'($urandom_range(deque_count - 1)))];
        end
        else if (roll < held_pct + 20)
        begin
            case ($urandom_range(3))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7FFF_FFFF;
                2:       v = 32'hFFFF_FFFF;
                default: v = $urandom_range(7);
            endcase
        end
        else
        begin
            v = $urandom;
        end
        return v;
    endfunction

    // Adds one directed row; untyped rows take their result from the predictor.
    function automatic void add_row(input logic [cdq_pkg::FUNC_W-1:0] op,
                                    input logic [cdq_pkg::DATA_W-1:0] arg,
                                    input bit typed,
                                    input logic [cdq_pkg::STATUS_W-1:0] st,
                                    input logic [cdq_pkg::DATA_W-1:0] popped,
                                    input logic [cdq_pkg::POS_W-1:0] pos,
                                    input logic [cdq_pkg::TOTAL_W-1:0] total);
        dir_row_t row;
        row.op                = op;
        row.arg               = arg;
        row.typed             = typed;
        row.want.status       = st;
        row.want.popped_value = popped;
        row.want.position     = pos;
        row.want.entry_total  = total;
        dir_rows.push_back(row);
    endfunction

    // Offers one request, waits for its transfer and records the owed result.
    task automatic send_request(input logic [cdq_pkg::FUNC_W-1:0] op,
                                input logic [cdq_pkg::DATA_W-1:0] arg,
                                input bit typed,
                                input cdq_pkg::res_t want);
        cdq_pkg::res_t predicted;
        if ($urandom_range(99) < send_idle_pct)
        begin
            // Idle gap with junk on the payload, which must be ignored.
            req_ch.valid <= 1'b0;
            req_ch.func  <= cdq_pkg::FUNC_W'($urandom);
            req_ch.value <= $urandom;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= op;
        req_ch.value <= arg;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        predicted = deque_apply(op, arg);
        owed_results.push_back(typed ? want : predicted);
    endtask

    // One random request; the draining mix favors pops.
    task automatic random_item(input bit drain);
        int                         roll;
        logic [cdq_pkg::FUNC_W-1:0] op;
        logic [cdq_pkg::DATA_W-1:0] arg;
        roll = $urandom_range(99);
        if (drain && roll < 45)
        begin
            op = (roll < 22) ? cdq_pkg::FUNC_POP_FRONT : cdq_pkg::FUNC_POP_BACK;
        end
        else
        begin
            roll = $urandom_range(99);
            if (roll < 18)
                op = cdq_pkg::FUNC_PUSH_FRONT;
            else if (roll < 36)
                op = cdq_pkg::FUNC_PUSH_BACK;
            else if (roll < 50)
                op = cdq_pkg::FUNC_POP_FRONT;
            else if (roll < 64)
                op = cdq_pkg::FUNC_POP_BACK;
            else if (roll < 80)
                op = cdq_pkg::FUNC_FIND;
            else if (roll < 95)
                op = cdq_pkg::FUNC_DELETE;
            else
                op = $urandom_range(1) ? FUNC_SPARE_A : FUNC_SPARE_B;
        end
        if (op == cdq_pkg::FUNC_PUSH_FRONT || op == cdq_pkg::FUNC_PUSH_BACK)
            arg = pick_value(15);
        else if (op == cdq_pkg::FUNC_FIND || op == cdq_pkg::FUNC_DELETE)
            arg = pick_value(60);
        else
            arg = $urandom;
        send_request(op, arg, 1'b0, '0);
    endtask

    // Result side: checks each transfer and decides ready for the next cycle.
    initial
    begin
        cdq_pkg::res_t want;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    report_mismatch($sformatf("result with no request pending, status %0d",
                                              res_ch.status));
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (res_ch.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  res_ch.status, want.status));
                    if (res_ch.popped_value !== want.popped_value)
                        report_mismatch($sformatf("popped_value %0d, expected %0d",
                                                  res_ch.popped_value, want.popped_value));
                    if (res_ch.position !== want.position)
                        report_mismatch($sformatf("position %0d, expected %0d",
                                                  res_ch.position, want.position));
                    if (res_ch.entry_total !== want.entry_total)
                        report_mismatch($sformatf("entry_total %0d, expected %0d",
                                                  res_ch.entry_total, want.entry_total));
                end
                result_count++;
            end
            // A requested hold-off keeps ready low for a counted stretch.
            if (hold_request > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_request--;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func  = cdq_pkg::FUNC_PUSH_FRONT;
        req_ch.value = '0;

        // Empty deque: pops, find, delete and the unused codes.
        add_row(cdq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1'b1, cdq_pkg::STATUS_EMPTY,
                32'h0, 8'd0, 9'd0);
        add_row(cdq_pkg::FUNC_POP_BACK,   32'h0000_0000, 1'b1, cdq_pkg::STATUS_EMPTY,
                32'h0, 8'd0, 9'd0);
        add_row(cdq_pkg::FUNC_FIND,       32'h0000_0000, 1'b1, cdq_pkg::STATUS_EMPTY,
                32'h0, 8'd0, 9'd0);
        add_row(cdq_pkg::FUNC_DELETE,     32'h8000_0000, 1'b1, cdq_pkg::STATUS_EMPTY,
                32'h0, 8'd0, 9'd0);
        add_row(FUNC_SPARE_A,             32'hFFFF_FFFF, 1'b1, cdq_pkg::STATUS_OK,
                32'h0, 8'd0, 9'd0);
        add_row(FUNC_SPARE_B,             32'h1234_5678, 1'b1, cdq_pkg::STATUS_OK,
                32'h0, 8'd0, 9'd0);
        // Extremes at both ends: front to back -1, min, max, 0.
        add_row(cdq_pkg::FUNC_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, cdq_pkg::STATUS_OK,
                32'h0, 8'd0, 9'd1);
        add_row(cdq_pkg::FUNC_PUSH_FRONT, 32'h8000_0000, 1'b1, cdq_pkg::STATUS_OK,
                32'h0, 8'd0, 9'd2);
        add_row(cdq_pkg::FUNC_PUSH_BACK,  32'h0000_0000, 1'b1, cdq_pkg::STATUS_OK,
                32'h0, 8'd0, 9'd3);
        add_row(cdq_pkg::FUNC_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, cdq_pkg::STATUS_OK,
                32'h0, 8'd0, 9'd4);
        add_row(cdq_pkg::FUNC_FIND,       32'h7FFF_FFFF, 1'b1, cdq_pkg::STATUS_OK,
                32'h0, 8'd2, 9'd4);
        add_row(cdq_pkg::FUNC_FIND,       32'h0000_0000, 1'b1, cdq_pkg::STATUS_OK,
                32'h0, 8'd3, 9'd4);
        add_row(cdq_pkg::FUNC_FIND,       32'hFFFF_FFFF, 1'b1, cdq_pkg::STATUS_OK,
                32'h0, 8'd0, 9'd4);
        add_row(cdq_pkg::FUNC_FIND,       32'h0000_0005, 1'b1, cdq_pkg::STATUS_EMPTY,
                32'h0, 8'd0, 9'd4);
        add_row(cdq_pkg::FUNC_DELETE,     32'h8000_0000, 1'b1, cdq_pkg::STATUS_OK,
                32'h0, 8'd1, 9'd3);
        add_row(cdq_pkg::FUNC_DELETE,     32'h0000_1234, 1'b1, cdq_pkg::STATUS_EMPTY,
                32'h0, 8'd0, 9'd3);
        add_row(cdq_pkg::FUNC_POP_BACK,   32'h0000_0000, 1'b1, cdq_pkg::STATUS_OK,
                32'h0, 8'd0, 9'd2);
        add_row(cdq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1'b1, cdq_pkg::STATUS_OK,
                32'hFFFF_FFFF, 8'd0, 9'd1);
        // Duplicates: find and delete must hit the first one.
        add_row(cdq_pkg::FUNC_PUSH_BACK,  32'h0000_0005, 1'b0, cdq_pkg::STATUS_OK,
                32'h0, 8'd0, 9'd0);
        add_row(cdq_pkg::FUNC_PUSH_BACK,  32'h7FFF_FFFF, 1'b0, cdq_pkg::STATUS_OK,
                32'h0, 8'd0, 9'd0);
        add_row(cdq_pkg::FUNC_FIND,       32'h7FFF_FFFF, 1'b0, cdq_pkg::STATUS_OK,
                32'h0, 8'd0, 9'd0);
        add_row(cdq_pkg::FUNC_DELETE,     32'h7FFF_FFFF, 1'b0, cdq_pkg::STATUS_OK,
                32'h0, 8'd0, 9'd0);
        add_row(cdq_pkg::FUNC_DELETE,     32'h7FFF_FFFF, 1'b0, cdq_pkg::STATUS_OK,
                32'h0, 8'd0, 9'd0);
        add_row(cdq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1'b0, cdq_pkg::STATUS_OK,
                32'h0, 8'd0, 9'd0);
        add_row(cdq_pkg::FUNC_POP_BACK,   32'h0000_0000, 1'b1, cdq_pkg::STATUS_EMPTY,
                32'h0, 8'd0, 9'd0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, back to back.
        foreach (dir_rows[k])
        begin
            send_request(dir_rows[k].op, dir_rows[k].arg, dir_rows[k].typed,
                         dir_rows[k].want);
        end

        // No idling, after a long result hold-off that backs up the input.
        hold_request = 300;
        repeat (150) random_item(1'b0);

        // Sender mostly idle: fill the deque, push into a full one, then mix.
        send_idle_pct = 87;
        while (deque_count < DEPTH)
        begin
            send_request($urandom_range(1) ? cdq_pkg::FUNC_PUSH_FRONT
                                           : cdq_pkg::FUNC_PUSH_BACK,
                         pick_value(15), 1'b0, '0);
        end
        repeat (4)
        begin
            send_request($urandom_range(1) ? cdq_pkg::FUNC_PUSH_FRONT
                                           : cdq_pkg::FUNC_PUSH_BACK,
                         $urandom, 1'b0, '0);
        end
        send_request(cdq_pkg::FUNC_FIND, deque_mem[slot_at(DEPTH - 1)], 1'b0, '0);
        repeat (30) random_item(1'b0);

        // Receiver mostly stalling while the deque drains.
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        repeat (150) random_item(1'b1);

        // Light idling on both sides.
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        repeat (200) random_item(1'b0);

        req_ch.valid <= 1'b0;
        while (owed_results.size() != 0)
        begin
            @(posedge clk);
        end
        // Room for a late, unexpected result after the slowest delete.
        repeat (3 * DEPTH) @(posedge clk);

        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Run limit.
    initial
    begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/cdq_pkg.sv
rtl/core/cdq_if.sv
rtl/core/cdq_ram.sv
rtl/core/cdq_ctrl.sv
rtl/core/circular_deque_with_search.sv
tb/tb_circular_deque_with_search.sv
